FILE: design/blcm_pkg.sv
// Shared types, register indexes and event codes of the battery level and charge monitor.
package blcm_pkg;

	localparam int AddrWidth = 5;

	localparam logic [2:0] REG_RATIO    = 3'd0;
	localparam logic [2:0] REG_EMPTY    = 3'd1;
	localparam logic [2:0] REG_FULL     = 3'd2;
	localparam logic [2:0] REG_LOW      = 3'd3;
	localparam logic [2:0] REG_JUMP_EN  = 3'd4;
	localparam logic [2:0] REG_JUMP_DLT = 3'd5;

	localparam logic [2:0] EV_REPORT = 3'd0;
	localparam logic [2:0] EV_LOW    = 3'd1;
	localparam logic [2:0] EV_FULL   = 3'd2;
	localparam logic [2:0] EV_BEGIN  = 3'd3;
	localparam logic [2:0] EV_STOP   = 3'd4;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_PIN    = 1'b1;

	typedef struct packed {
		logic [11:0] divider_ratio_q8;
		logic [15:0] empty_millivolts;
		logic [15:0] full_millivolts;
		logic [6:0]  low_percent;
		logic        jump_detect_enable;
		logic [15:0] jump_delta_millivolts;
	} cfg_t;

	typedef struct packed {
		logic        operation;
		logic        pin_level;
		logic [15:0] millivolts;
		logic        has_jump;
		logic [2:0]  jump_code;
	} job_t;

endpackage

FILE: design/blcm_front.sv
// Front part: accepts items, scales samples and classifies charge jumps.
module blcm_front (
	input  logic               clk,
	input  logic               arst_n,
	input  blcm_pkg::cfg_t     cfg,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic               operation,
	input  logic [11:0]        sample_millivolts,
	input  logic               pin_level,
	output logic               push,
	output blcm_pkg::job_t     push_job,
	input  logic               push_ready
);

	logic        valid_s1;
	logic        op_s1;
	logic        pin_s1;
	logic [11:0] sample_s1;
	logic        valid_s2;
	logic        op_s2;
	logic        pin_s2;
	logic [15:0] v_s2;
	logic [15:0] prev_q;
	logic        chg_q;
	logic [23:0] product;
	logic [16:0] limit;
	logic        rise;
	logic        fall;
	logic        adv1;
	logic        adv2;

	assign product  = {12'd0, sample_s1} * {12'd0, cfg.divider_ratio_q8};
	assign adv2     = valid_s2 && push_ready;
	assign adv1     = valid_s1 && (!valid_s2 || adv2);
	assign s_tready = !valid_s1 || adv1;
	assign limit    = {1'b0, prev_q} + {1'b0, cfg.jump_delta_millivolts};
	assign rise     = {1'b0, v_s2} > limit;
	assign fall     = v_s2 <= prev_q;

	always_comb begin
		push_job.operation  = op_s2;
		push_job.pin_level  = pin_s2;
		push_job.millivolts = (op_s2 == blcm_pkg::OP_PIN) ? 16'd0 : v_s2;
		push_job.has_jump   = 1'b0;
		push_job.jump_code  = blcm_pkg::EV_BEGIN;
		if (op_s2 == blcm_pkg::OP_PIN) begin
			push_job.has_jump  = 1'b1;
			push_job.jump_code = pin_s2 ? blcm_pkg::EV_BEGIN : blcm_pkg::EV_STOP;
		end else if (cfg.jump_detect_enable) begin
			if (rise) begin
				push_job.has_jump  = !chg_q;
				push_job.jump_code = blcm_pkg::EV_BEGIN;
			end else if (fall && chg_q) begin
				push_job.has_jump  = 1'b1;
				push_job.jump_code = blcm_pkg::EV_STOP;
			end
		end
	end

	assign push = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			prev_q   <= 16'd0;
			chg_q    <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				valid_s1 <= 1'b1;
			end else if (adv1) begin
				valid_s1 <= 1'b0;
			end
			if (adv1) begin
				valid_s2 <= 1'b1;
			end else if (adv2) begin
				valid_s2 <= 1'b0;
			end
			if (adv2 && op_s2 == blcm_pkg::OP_SAMPLE) begin
				prev_q <= v_s2;
				if (cfg.jump_detect_enable) begin
					if (rise) begin
						chg_q <= 1'b1;
					end else if (fall) begin
						chg_q <= 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1     <= operation;
			pin_s1    <= pin_level;
			sample_s1 <= sample_millivolts;
		end
		if (adv1) begin
			op_s2  <= op_s1;
			pin_s2 <= pin_s1;
			v_s2   <= product[23:8];
		end
	end

endmodule

FILE: design/blcm_queue.sv
// Two-entry job queue between the front and back parts.
module blcm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  blcm_pkg::job_t push_job,
	output logic           push_ready,
	input  logic           pop,
	output logic           pop_valid,
	output blcm_pkg::job_t pop_job
);

	blcm_pkg::job_t slot_q [2];
	logic [1:0]     count_q;
	logic           wr_q;
	logic           rd_q;
	logic           do_push;
	logic           do_pop;

	assign push_ready = count_q != 2'd2;
	assign pop_valid  = count_q != 2'd0;
	assign pop_job    = slot_q[rd_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_job;
		end
	end

endmodule

FILE: design/blcm_back.sv
// Back part: percent divider, low and full tests, and result sequencing.
module blcm_back (
	input  logic           clk,
	input  logic           arst_n,
	input  blcm_pkg::cfg_t cfg,
	input  logic           pop_valid,
	input  blcm_pkg::job_t pop_job,
	output logic           pop,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [2:0]     event_code,
	output logic [15:0]    battery_millivolts,
	output logic [6:0]     percent,
	output logic           last_of_run
);

	typedef enum logic [1:0] {
		B_IDLE,
		B_SETUP,
		B_DIV,
		B_EMIT
	} bstate_t;

	bstate_t        state_q;
	blcm_pkg::job_t job_q;
	logic [22:0]    num_q;
	logic [22:0]    rem_q;
	logic [22:0]    dsh_q;
	logic [15:0]    den_q;
	logic [22:0]    lowprod_q;
	logic [5:0]     quo_q;
	logic [2:0]     cnt_q;
	logic           first_q;
	logic [6:0]     pct_q;
	logic [3:0]     pend_q;
	logic           m_valid_q;
	logic [2:0]     code_q;
	logic [15:0]    mv_q;
	logic [6:0]     pct_o_q;
	logic           last_q;

	logic           ge_full;
	logic           le_empty;
	logic [15:0]    diff;
	logic [15:0]    span;
	logic [22:0]    num;
	logic           qbit;
	logic           out_free;
	logic [3:0]     pick;
	logic [2:0]     pick_code;

	assign ge_full  = job_q.millivolts >= cfg.full_millivolts;
	assign le_empty = job_q.millivolts <= cfg.empty_millivolts;
	assign diff     = job_q.millivolts - cfg.empty_millivolts;
	assign span     = cfg.full_millivolts - cfg.empty_millivolts;
	assign num      = {1'b0, diff, 6'd0} + {2'b0, diff, 5'd0} + {5'd0, diff, 2'd0};
	assign qbit     = rem_q >= dsh_q;
	assign out_free = !m_valid_q || m_tready;
	assign pop      = (state_q == B_IDLE) && pop_valid;

	always_comb begin
		pick      = 4'b1000;
		pick_code = blcm_pkg::EV_FULL;
		if (pend_q[0]) begin
			pick      = 4'b0001;
			pick_code = job_q.jump_code;
		end else if (pend_q[1]) begin
			pick      = 4'b0010;
			pick_code = blcm_pkg::EV_REPORT;
		end else if (pend_q[2]) begin
			pick      = 4'b0100;
			pick_code = blcm_pkg::EV_LOW;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			m_valid_q <= 1'b0;
			pend_q    <= 4'd0;
			cnt_q     <= 3'd0;
			first_q   <= 1'b0;
		end else begin
			if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (pop_valid) begin
						state_q <= B_SETUP;
					end
				end
				B_SETUP: begin
					if (job_q.operation == blcm_pkg::OP_PIN) begin
						pend_q  <= 4'b0001;
						state_q <= B_EMIT;
					end else if (ge_full) begin
						pend_q  <= {1'b1, 7'd100 <= cfg.low_percent, 1'b1, job_q.has_jump};
						state_q <= B_EMIT;
					end else if (le_empty) begin
						pend_q  <= {1'b0, 1'b1, 1'b1, job_q.has_jump};
						state_q <= B_EMIT;
					end else begin
						cnt_q   <= 3'd6;
						first_q <= 1'b1;
						state_q <= B_DIV;
					end
				end
				B_DIV: begin
					first_q <= 1'b0;
					cnt_q   <= cnt_q - 3'd1;
					if (cnt_q == 3'd0) begin
						pend_q  <= {1'b0, num_q <= lowprod_q, 1'b1, job_q.has_jump};
						state_q <= B_EMIT;
					end
				end
				B_EMIT: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						pend_q    <= pend_q & ~pick;
						if ((pend_q & ~pick) == 4'd0) begin
							state_q <= B_IDLE;
						end
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= pop_job;
		end
		if (state_q == B_SETUP) begin
			num_q <= num;
			rem_q <= num;
			den_q <= span;
			dsh_q <= {1'b0, span, 6'd0};
			if (job_q.operation == blcm_pkg::OP_PIN) begin
				pct_q <= 7'd0;
			end else if (ge_full) begin
				pct_q <= 7'd100;
			end else if (le_empty) begin
				pct_q <= 7'd0;
			end
		end
		if (state_q == B_DIV) begin
			if (first_q) begin
				lowprod_q <= {16'd0, cfg.low_percent} * {7'd0, den_q};
			end
			if (qbit) begin
				rem_q <= rem_q - dsh_q;
			end
			dsh_q <= {1'b0, dsh_q[22:1]};
			quo_q <= {quo_q[4:0], qbit};
			if (cnt_q == 3'd0) begin
				pct_q <= {quo_q, qbit};
			end
		end
		if (state_q == B_EMIT && out_free) begin
			code_q  <= pick_code;
			mv_q    <= job_q.millivolts;
			pct_o_q <= pct_q;
			last_q  <= (pend_q & ~pick) == 4'd0;
		end
	end

	assign m_tvalid           = m_valid_q;
	assign event_code         = code_q;
	assign battery_millivolts = mv_q;
	assign percent            = pct_o_q;
	assign last_of_run        = last_q;

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_DIV |-> den_q != 16'd0)
		else $error("percent divider running with zero span");

	a_emit_pending: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_EMIT |-> pend_q != 4'd0)
		else $error("emit state with no result pending");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> pct_o_q <= 7'd100)
		else $error("percent above one hundred");

	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_DIV && cnt_q == 3'd0 |=> state_q == B_EMIT)
		else $error("divider did not hand over to emit");

endmodule

FILE: design/battery_level_charge_monitor.sv
// Top level of the battery level and charge monitor with its register file.
//
// Input beats arrive on the s_ group: tuser is the operation (0 sample, 1 pin edge),
// tdata holds the ADC millivolts and the pin level. Each beat yields one to four
// result beats on the m_ group, the last one of a beat's run marked by tlast.
// A sample is scaled by the divider ratio, checked for a charging jump against
// the previous sample, and reported with its percent, then low and full events.
// The front stages s1 and s2 are registered, then a two-entry queue feeds the back part.
// The back part takes a pin edge or a clamped sample from setup straight to emit, and
// a sample between empty and full through the seven-step percent divider, which sets
// the figure, before it emits the result beats of that input beat in turn.
// The front keeps accepting while the queue has room, so a stalled receiver
// holds the output register and fills the queue before s_tready drops.
// Write registers over the APB port only while idle; the block does not enforce this.
// Reset loads the register defaults, clears the previous sample and the
// charging flag, and empties the pipeline and queue.
module battery_level_charge_monitor (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [blcm_pkg::AddrWidth-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [15:0]                    s_tdata,  // sample_millivolts[11:0], pin_level[12], zero
	input  logic                           s_tuser,  // operation
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [23:0]                    m_tdata,  // battery_millivolts[15:0], percent[22:16], zero
	output logic [2:0]                     m_tuser,  // event_code
	output logic                           m_tlast
);

	blcm_pkg::cfg_t cfg_q;
	blcm_pkg::job_t push_job;
	blcm_pkg::job_t pop_job;
	logic           push;
	logic           push_ready;
	logic           pop;
	logic           pop_valid;
	logic [15:0]    mv;
	logic [6:0]     pct;
	logic           wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.divider_ratio_q8      <= 12'd512;
			cfg_q.empty_millivolts      <= 16'd3000;
			cfg_q.full_millivolts       <= 16'd4200;
			cfg_q.low_percent           <= 7'd20;
			cfg_q.jump_detect_enable    <= 1'b1;
			cfg_q.jump_delta_millivolts <= 16'd100;
		end else if (wr_en) begin
			case (paddr[4:2])
				blcm_pkg::REG_RATIO:    cfg_q.divider_ratio_q8      <= pwdata[11:0];
				blcm_pkg::REG_EMPTY:    cfg_q.empty_millivolts      <= pwdata[15:0];
				blcm_pkg::REG_FULL:     cfg_q.full_millivolts       <= pwdata[15:0];
				blcm_pkg::REG_LOW:      cfg_q.low_percent           <= pwdata[6:0];
				blcm_pkg::REG_JUMP_EN:  cfg_q.jump_detect_enable    <= pwdata[0];
				blcm_pkg::REG_JUMP_DLT: cfg_q.jump_delta_millivolts <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			blcm_pkg::REG_RATIO:    prdata = {20'd0, cfg_q.divider_ratio_q8};
			blcm_pkg::REG_EMPTY:    prdata = {16'd0, cfg_q.empty_millivolts};
			blcm_pkg::REG_FULL:     prdata = {16'd0, cfg_q.full_millivolts};
			blcm_pkg::REG_LOW:      prdata = {25'd0, cfg_q.low_percent};
			blcm_pkg::REG_JUMP_EN:  prdata = {31'd0, cfg_q.jump_detect_enable};
			blcm_pkg::REG_JUMP_DLT: prdata = {16'd0, cfg_q.jump_delta_millivolts};
			default:                prdata = 32'd0;
		endcase
	end

	blcm_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg_q),
		.s_tvalid          (s_tvalid),
		.s_tready          (s_tready),
		.operation         (s_tuser),
		.sample_millivolts (s_tdata[11:0]),
		.pin_level         (s_tdata[12]),
		.push              (push),
		.push_job          (push_job),
		.push_ready        (push_ready)
	);

	blcm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_valid  (pop_valid),
		.pop_job    (pop_job)
	);

	blcm_back u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg                (cfg_q),
		.pop_valid          (pop_valid),
		.pop_job            (pop_job),
		.pop                (pop),
		.m_tvalid           (m_tvalid),
		.m_tready           (m_tready),
		.event_code         (m_tuser),
		.battery_millivolts (mv),
		.percent            (pct),
		.last_of_run        (m_tlast)
	);

	assign m_tdata = {1'b0, pct, mv};

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench of the battery level and charge monitor with a stream driver and monitor.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WatchdogLimit = 4000;

	typedef struct {
		logic        op;
		logic [11:0] sample;
		logic        pin;
		logic        hold;
	} adc_beat_t;

	typedef struct {
		logic [2:0]  code;
		logic [15:0] mv;
		logic [6:0]  pct;
		logic        last;
	} report_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           psel = 1'b0;
	logic                           penable = 1'b0;
	logic                           pwrite = 1'b0;
	logic [blcm_pkg::AddrWidth-1:0] paddr = '0;
	logic [31:0]                    pwdata = '0;
	logic [31:0]                    prdata;
	logic                           pready;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [15:0]                    s_tdata = '0;  // sample_millivolts[11:0], pin_level[12], zero
	logic                           s_tuser = 1'b0;  // operation
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [23:0]                    m_tdata;  // battery_millivolts[15:0], percent[22:16], zero
	logic [2:0]                     m_tuser;  // event_code

	logic                           m_tlast;

	blcm_pkg::cfg_t cfg;
	logic [15:0]    prev_mv;
	logic           charging;

	adc_beat_t beats_to_send[$];
	adc_beat_t in_flight;
	report_t   due_reports[$];
	report_t   oldest;

	int send_idle = 29;
	int recv_idle = 45;
	int walk = 1500;
	int mismatches = 0;
	int quiet_cycles = 0;

	battery_level_charge_monitor u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #1 clk = ~clk;

	function automatic void predict_reports(input adc_beat_t beat);
		report_t     run[$];
		logic [31:0] scaled;
		logic [15:0] v;
		logic [31:0] num;
		logic [31:0] den;
		logic [6:0]  pct;
		logic        low;
		if (beat.op == blcm_pkg::OP_PIN) begin
			run.push_back('{beat.pin ? blcm_pkg::EV_BEGIN : blcm_pkg::EV_STOP,
				16'd0, 7'd0, 1'b0});
		end else begin
			scaled = (32'(beat.sample) * 32'(cfg.divider_ratio_q8)) >> 8;
			v = (scaled > 32'hFFFF) ? 16'hFFFF : scaled[15:0];
			if (v >= cfg.full_millivolts) begin
				pct = 7'd100;
				low = (cfg.low_percent >= 7'd100);
			end else if (v <= cfg.empty_millivolts) begin
				pct = 7'd0;
				low = 1'b1;
			end else begin
				num = (32'(v) - 32'(cfg.empty_millivolts)) * 32'd100;
				den = 32'(cfg.full_millivolts) - 32'(cfg.empty_millivolts);
				pct = 7'(num / den);
				low = (num <= 32'(cfg.low_percent) * den);
			end
			if (cfg.jump_detect_enable) begin
				if (32'(v) > 32'(prev_mv) + 32'(cfg.jump_delta_millivolts)) begin
					if (!charging) begin
						charging = 1'b1;
						run.push_back('{blcm_pkg::EV_BEGIN, v, pct, 1'b0});
					end
				end else if (v <= prev_mv && charging) begin
					charging = 1'b0;
					run.push_back('{blcm_pkg::EV_STOP, v, pct, 1'b0});
				end
			end
			run.push_back('{blcm_pkg::EV_REPORT, v, pct, 1'b0});
			if (low)
				run.push_back('{blcm_pkg::EV_LOW, v, pct, 1'b0});
			if (v >= cfg.full_millivolts)
				run.push_back('{blcm_pkg::EV_FULL, v, pct, 1'b0});
			prev_mv = v;
		end
		run[run.size()-1].last = 1'b1;
		foreach (run[i])
			due_reports.push_back(run[i]);
	endfunction

	function automatic void check_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				predict_reports(in_flight);
			if (!s_tvalid || s_tready) begin
				if (beats_to_send.size() != 0
						&& !(beats_to_send[0].hold && due_reports.size() != 0)
						&& $urandom_range(0, 99) >= send_idle) begin
					in_flight = beats_to_send.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {3'b000, in_flight.pin, in_flight.sample};
					s_tuser <= in_flight.op;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(0, 99) >= recv_idle);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (due_reports.size() == 0) begin
				$display("%0t: unexpected beat, expected none, actual event %0d data %0h",
					$time, m_tuser, m_tdata);
				mismatches++;
			end else begin
				oldest = due_reports.pop_front();
				check_field("event_code", 32'(oldest.code), 32'(m_tuser));
				check_field("battery_millivolts", 32'(oldest.mv), 32'(m_tdata[15:0]));
				check_field("percent", 32'(oldest.pct), 32'(m_tdata[22:16]));
				check_field("tdata padding", 32'd0, 32'(m_tdata[23]));
				check_field("last_of_run", 32'(oldest.last), 32'(m_tlast));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchdogLimit) begin
			$display("testbench failed");
			$finish;
		end
	end

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			blcm_pkg::REG_RATIO:    cfg.divider_ratio_q8 = value[11:0];
			blcm_pkg::REG_EMPTY:    cfg.empty_millivolts = value[15:0];
			blcm_pkg::REG_FULL:     cfg.full_millivolts = value[15:0];
			blcm_pkg::REG_LOW:      cfg.low_percent = value[6:0];
			blcm_pkg::REG_JUMP_EN:  cfg.jump_detect_enable = value[0];
			blcm_pkg::REG_JUMP_DLT: cfg.jump_delta_millivolts = value[15:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input int ratio, input int empty_mv, input int full_mv,
			input int low_pct, input int jump_en, input int delta_mv);
		reg_write(blcm_pkg::REG_RATIO, ratio);
		reg_write(blcm_pkg::REG_EMPTY, empty_mv);
		reg_write(blcm_pkg::REG_FULL, full_mv);
		reg_write(blcm_pkg::REG_LOW, low_pct);
		reg_write(blcm_pkg::REG_JUMP_EN, jump_en);
		reg_write(blcm_pkg::REG_JUMP_DLT, delta_mv);
	endtask

	task automatic queue_beat(input logic op, input int sample, input logic pin);
		beats_to_send.push_back('{op, 12'(sample), pin, 1'b0});
	endtask

	task automatic queue_random(input int count, input int hold_at);
		adc_beat_t beat;
		int        target;
		for (int k = 0; k < count; k++) begin
			beat.hold = (k == hold_at) || ($urandom_range(0, 59) == 0);
			beat.op = blcm_pkg::OP_SAMPLE;
			beat.pin = 1'($urandom_range(0, 1));
			beat.sample = 12'($urandom_range(0, 4095));
			case ($urandom_range(0, 9))
				0: beat.op = blcm_pkg::OP_PIN;
				1, 2: walk = $urandom_range(0, 4095);
				3: ;
				4: walk = walk - int'($urandom_range(0, 64));
				5: walk = walk + int'($urandom_range(0, 64));
				6, 7: walk = walk + int'($urandom_range(0, 1500));
				default: begin
					target = $urandom_range(0, 1) ? int'(cfg.empty_millivolts)
						: int'(cfg.full_millivolts);
					target = target + int'($urandom_range(0, 8)) - 4;
					if (cfg.divider_ratio_q8 != 0)
						walk = (target * 256) / int'(cfg.divider_ratio_q8)
							+ int'($urandom_range(0, 2)) - 1;
				end
			endcase
			if (walk < 0)
				walk = 0;
			if (walk > 4095)
				walk = 4095;
			if (beat.op == blcm_pkg::OP_SAMPLE)
				beat.sample = 12'(walk);
			beats_to_send.push_back(beat);
		end
	endtask

	task automatic wait_idle(input int tail);
		while (beats_to_send.size() != 0 || s_tvalid || due_reports.size() != 0)
			@(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	task automatic set_idling(input int phase);
		if (phase < 4) begin
			send_idle = 29;
			recv_idle = 45;
		end else if (phase < 7) begin
			send_idle = 45;
			recv_idle = 29;
		end else begin
			send_idle = 0;
			recv_idle = 0;
		end
	endtask

	initial begin
		cfg = '{12'd512, 16'd3000, 16'd4200, 7'd20, 1'b1, 16'd100};
		prev_mv = '0;
		charging = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values first: exact low boundary, floored percent and jump edges.
		set_idling(0);
		queue_beat(blcm_pkg::OP_PIN, 0, 1'b1);
		queue_beat(blcm_pkg::OP_PIN, 4095, 1'b0);
		queue_beat(blcm_pkg::OP_SAMPLE, 0, 1'b1);
		queue_beat(blcm_pkg::OP_SAMPLE, 4095, 1'b0);
		queue_beat(blcm_pkg::OP_SAMPLE, 4095, 1'b0);
		queue_beat(blcm_pkg::OP_SAMPLE, 1500, 1'b0);
		queue_beat(blcm_pkg::OP_SAMPLE, 1501, 1'b0);
		queue_beat(blcm_pkg::OP_SAMPLE, 1620, 1'b0);
		queue_beat(blcm_pkg::OP_SAMPLE, 1621, 1'b0);
		queue_beat(blcm_pkg::OP_SAMPLE, 2099, 1'b0);
		queue_beat(blcm_pkg::OP_SAMPLE, 2100, 1'b0);
		queue_beat(blcm_pkg::OP_SAMPLE, 1650, 1'b0);
		queue_beat(blcm_pkg::OP_SAMPLE, 1700, 1'b0);
		queue_beat(blcm_pkg::OP_SAMPLE, 1701, 1'b0);
		queue_beat(blcm_pkg::OP_SAMPLE, 1750, 1'b1);
		queue_beat(blcm_pkg::OP_SAMPLE, 1700, 1'b0);
		queue_beat(blcm_pkg::OP_PIN, 0, 1'b1);
		queue_beat(blcm_pkg::OP_SAMPLE, 1600, 1'b0);
		queue_beat(blcm_pkg::OP_SAMPLE, 0, 1'b0);
		queue_beat(blcm_pkg::OP_SAMPLE, 2500, 1'b0);
		wait_idle(30);

		for (int phase = 1; phase <= 9; phase++) begin
			set_idling(phase);
			case (phase)
				1: set_config(4095, 0, 65535, 0, 1, 0);
				2: set_config(0, 0, 0, 100, 0, 65535);
				3: set_config(300, 65535, 3000, 127, 1, 65535);
				4: set_config(256, 1000, 4000, 50, 1, 200);
				5: set_config(512, 3000, 4200, 20, 1, 100);
				default: set_config($urandom_range(128, 1024), $urandom_range(0, 9000),
					$urandom_range(0, 15000), $urandom_range(0, 110),
					$urandom_range(0, 1), $urandom_range(0, 400));
			endcase
			if (phase == 6)
				cfg.full_millivolts = cfg.full_millivolts;
			queue_random(45, (phase == 4) ? 10 : -1);
			wait_idle(30);
		end

		wait_idle(40);
		if (mismatches == 0 && due_reports.size() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
